@@ sv/rhh_pkg.sv @@
package rhh_pkg;

    // Command codes carried with each input item.
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    // Result status codes.
    typedef enum logic [2:0] {
        RES_NEW       = 3'd0,
        RES_UPDATED   = 3'd1,
        RES_FOUND     = 3'd2,
        RES_NOT_FOUND = 3'd3,
        RES_REMOVED   = 3'd4,
        RES_FULL      = 3'd5,
        RES_CLEARED   = 3'd6
    } res_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_HASH1,
        ST_HASH2,
        ST_HASH3,
        ST_MOD,
        ST_FIND,
        ST_PROBE,
        ST_PLACE,
        ST_SHIFT,
        ST_CLEAR,
        ST_RESP
    } state_t;

    // Slot index operations.
    typedef enum logic [1:0] {
        IDX_HOLD,
        IDX_HOME,
        IDX_NEXT,
        IDX_ZERO
    } idx_op_t;

    // Slot memory write operations.
    typedef enum logic [2:0] {
        WR_NONE,
        WR_CLEAR,
        WR_UPDATE,
        WR_TRAVEL,
        WR_SHIFT,
        WR_EMPTY
    } wr_op_t;

    // Travelling probe distance operations.
    typedef enum logic [1:0] {
        DIST_HOLD,
        DIST_ZERO,
        DIST_INC,
        DIST_QINC
    } dist_op_t;

    // Entry count operations.
    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_ZERO
    } cnt_op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load_in;
        logic     hash1;
        logic     hash2;
        logic     hash3;
        logic     mod_step;
        idx_op_t  idx_op;
        wr_op_t   wr_op;
        logic     swap;
        logic     hole_load;
        dist_op_t dist_op;
        cnt_op_t  cnt_op;
        logic     step_clr;
        logic     step_inc;
        logic     set_res;
        res_t     res_code;
        logic     res_from_q;
        logic     load_out;
    } ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        cmd_t cmd;
        logic pow2;
        logic mod_last;
        logic hit;
        logic miss;
        logic empty;
        logic richer;
        logic shift_stop;
        logic sweep_last;
        logic room;
        logic out_busy;
    } sts_t;

    localparam logic [31:0] MIX_MULT = 32'h045d_9f3b;

    // One mixing round: arithmetic shift right by 16, xor with itself.
    function automatic logic [31:0] mix16(input logic [31:0] x);
        mix16 = {{16{x[31]}}, x[31:16]} ^ x;
    endfunction

endpackage

@@ sv/robin_hood_hash_table_unit.sv @@
// An item passes through the hashing states, then, when TABLE_SLOTS is not a power of two,
// a reciprocal remainder step for the home slot, then probe, placement or shift steps.
// One item is handled at a time; the next is taken in the cycle after the result register
// is loaded.
// Clear writes one slot per cycle through the single write port.
// Reset (synchronous, active low) starts a clearing pass over every slot of the slot
// memory, during which no item is accepted; max_entries returns to 48.
module robin_hood_hash_table_unit
    import rhh_pkg::*;
#(
    parameter int TABLE_SLOTS = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // key[31:0], value[63:32]
    input  logic [1:0]  s_tuser,  // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // value_out[31:0], entry_count[38:32], zero[39]
    output logic [2:0]  m_tuser,  // status[2:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [6:0] max_entries_reg;
    ctl_t       ctl;
    sts_t       st;

    // Configuration register.
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_entries_reg <= 7'd48;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            max_entries_reg <= pwdata[6:0];
        end
    end
    assign prdata = paddr[2] ? 32'd0 : {25'd0, max_entries_reg};

    rhh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .ctl      (ctl)
    );

    rhh_datapath #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .max_entries (max_entries_reg),
        .m_tready    (m_tready),
        .ctl         (ctl),
        .st          (st),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

@@ sv/rhh_ctrl.sv @@
module rhh_ctrl
    import rhh_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t st,
    output ctl_t ctl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                if (st.sweep_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_HASH1;
            end
            ST_HASH1: begin
                state_next = (st.cmd == CMD_CLEAR) ? ST_CLEAR : ST_HASH2;
            end
            ST_HASH2: state_next = ST_HASH3;
            ST_HASH3: state_next = st.pow2 ? ST_FIND : ST_MOD;
            ST_MOD: begin
                if (st.mod_last) state_next = ST_FIND;
            end
            ST_FIND: state_next = ST_PROBE;
            ST_PROBE: begin
                if (st.hit) begin
                    state_next = (st.cmd == CMD_REMOVE) ? ST_SHIFT : ST_RESP;
                end else if (st.miss) begin
                    state_next = (st.cmd == CMD_INSERT && st.room) ? ST_PLACE : ST_RESP;
                end
            end
            ST_PLACE: begin
                if (st.empty) state_next = ST_RESP;
            end
            ST_SHIFT: begin
                if (st.shift_stop) state_next = ST_RESP;
            end
            ST_CLEAR: begin
                if (st.sweep_last) state_next = ST_RESP;
            end
            ST_RESP: begin
                if (!st.out_busy) state_next = ST_IDLE;
            end
            default: state_next = ST_INIT;
        endcase
    end

    // Command outputs.
    always_comb begin
        ctl.load_in    = 1'b0;
        ctl.hash1      = 1'b0;
        ctl.hash2      = 1'b0;
        ctl.hash3      = 1'b0;
        ctl.mod_step   = 1'b0;
        ctl.idx_op     = IDX_HOLD;
        ctl.wr_op      = WR_NONE;
        ctl.swap       = 1'b0;
        ctl.hole_load  = 1'b0;
        ctl.dist_op    = DIST_HOLD;
        ctl.cnt_op     = CNT_HOLD;
        ctl.step_clr   = 1'b0;
        ctl.step_inc   = 1'b0;
        ctl.set_res    = 1'b0;
        ctl.res_code   = RES_NEW;
        ctl.res_from_q = 1'b0;
        ctl.load_out   = 1'b0;
        unique case (state_reg)
            ST_INIT, ST_CLEAR: begin
                ctl.wr_op  = WR_CLEAR;
                ctl.idx_op = IDX_NEXT;
                if (st.sweep_last) begin
                    ctl.cnt_op = CNT_ZERO;
                    if (state_reg == ST_CLEAR) begin
                        ctl.set_res  = 1'b1;
                        ctl.res_code = RES_CLEARED;
                    end
                end
            end
            ST_IDLE: begin
                ctl.load_in = s_tvalid;
            end
            ST_HASH1: begin
                ctl.hash1  = 1'b1;
                ctl.idx_op = IDX_ZERO;
            end
            ST_HASH2: ctl.hash2 = 1'b1;
            ST_HASH3: ctl.hash3 = 1'b1;
            ST_MOD:   ctl.mod_step = 1'b1;
            ST_FIND: begin
                ctl.idx_op  = IDX_HOME;
                ctl.dist_op = DIST_ZERO;
            end
            ST_PROBE: begin
                if (st.hit) begin
                    ctl.set_res    = 1'b1;
                    ctl.res_from_q = 1'b1;
                    unique case (st.cmd)
                        CMD_INSERT: begin
                            ctl.res_code = RES_UPDATED;
                            ctl.wr_op    = WR_UPDATE;
                        end
                        CMD_REMOVE: begin
                            ctl.res_code  = RES_REMOVED;
                            ctl.hole_load = 1'b1;
                            ctl.idx_op    = IDX_NEXT;
                            ctl.step_clr  = 1'b1;
                        end
                        default: ctl.res_code = RES_FOUND;
                    endcase
                end else if (st.miss) begin
                    if (st.cmd == CMD_INSERT) begin
                        if (!st.room) begin
                            ctl.set_res  = 1'b1;
                            ctl.res_code = RES_FULL;
                        end
                    end else begin
                        ctl.set_res  = 1'b1;
                        ctl.res_code = RES_NOT_FOUND;
                    end
                end else begin
                    ctl.idx_op  = IDX_NEXT;
                    ctl.dist_op = DIST_INC;
                end
            end
            ST_PLACE: begin
                if (st.empty) begin
                    ctl.wr_op    = WR_TRAVEL;
                    ctl.cnt_op   = CNT_INC;
                    ctl.set_res  = 1'b1;
                    ctl.res_code = RES_NEW;
                end else if (st.richer) begin
                    ctl.wr_op   = WR_TRAVEL;
                    ctl.swap    = 1'b1;
                    ctl.dist_op = DIST_QINC;
                    ctl.idx_op  = IDX_NEXT;
                end else begin
                    ctl.dist_op = DIST_INC;
                    ctl.idx_op  = IDX_NEXT;
                end
            end
            ST_SHIFT: begin
                if (st.shift_stop) begin
                    ctl.wr_op  = WR_EMPTY;
                    ctl.cnt_op = CNT_DEC;
                end else begin
                    ctl.wr_op     = WR_SHIFT;
                    ctl.hole_load = 1'b1;
                    ctl.idx_op    = IDX_NEXT;
                    ctl.step_inc  = 1'b1;
                end
            end
            ST_RESP: begin
                ctl.load_out = !st.out_busy;
            end
            default: ;
        endcase
    end

    // A hit on lookup always goes straight to the result.
    a_lookup_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PROBE && st.hit && st.cmd == CMD_LOOKUP) |=> state_reg == ST_RESP)
        else $error("lookup hit did not move to response");

    // The clearing pass ends only on the last slot.
    a_sweep_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR && !st.sweep_last) |=> state_reg == ST_CLEAR)
        else $error("clearing pass ended early");

    // No item is taken while a result is still being produced.
    a_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESP && st.out_busy) |=> !s_tready)
        else $error("item taken while result pending");

endmodule

@@ sv/rhh_datapath.sv @@
module rhh_datapath
    import rhh_pkg::*;
#(
    parameter int TABLE_SLOTS = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [63:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic [6:0]  max_entries,
    input  logic        m_tready,
    input  ctl_t        ctl,
    output sts_t        st,
    output logic        m_tvalid,
    output logic [39:0] m_tdata,
    output logic [2:0]  m_tuser
);

    localparam int IW  = $clog2(TABLE_SLOTS);
    localparam int CW  = $clog2(TABLE_SLOTS + 1);
    localparam int LW  = (CW > 7) ? CW : 7;
    localparam int SVW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
    localparam int EW  = 1 + IW + 32 + SVW;
    localparam logic POW2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);
    localparam logic [IW:0]   NS    = (IW + 1)'(TABLE_SLOTS);
    localparam logic [IW-1:0] LAST  = IW'(TABLE_SLOTS - 1);
    localparam logic [31:0]   RECIP = 32'((64'd1 << 32) / TABLE_SLOTS);

    logic [EW-1:0] mem [TABLE_SLOTS];
    logic [EW-1:0] q_reg;

    cmd_t            cmd_reg;
    logic [31:0]     key_reg;
    logic [SVW-1:0]  val_reg;
    logic [31:0]     x_reg;
    logic [31:0]     hsh_reg;
    logic [31:0]     qt_reg;
    logic [IW-1:0]   r_reg;
    logic [4:0]      bit_reg;
    logic [IW-1:0]   idx_reg;
    logic [IW-1:0]   idx_next;
    logic [IW-1:0]   hole_reg;
    logic [IW-1:0]   dist_reg;
    logic [IW:0]     step_reg;
    logic [CW-1:0]   cnt_reg;
    res_t            res_reg;
    logic [31:0]     vout_reg;
    logic            out_valid_reg;
    logic [2:0]      out_status_reg;
    logic [31:0]     out_vout_reg;
    logic [6:0]      out_count_reg;

    logic            q_occ;
    logic [IW-1:0]   q_dist;
    logic [31:0]     q_key;
    logic [SVW-1:0]  q_val;
    logic [IW-1:0]   idx_inc;
    logic [IW-1:0]   home;
    logic [63:0]     prod;
    logic [IW:0]     rem_est;
    logic            we;
    logic [IW-1:0]   wa;
    logic [EW-1:0]   wd;
    logic [LW-1:0]   lim;
    logic            poorer;

    assign {q_occ, q_dist, q_key, q_val} = q_reg;
    assign idx_inc = (idx_reg == LAST) ? '0 : idx_reg + 1'b1;
    assign home    = POW2 ? hsh_reg[IW-1:0] : r_reg;
    assign prod    = 64'(hsh_reg) * 64'(RECIP);
    assign rem_est = hsh_reg[IW:0] - qt_reg[IW:0] * NS;

    // Input capture, the three hashing stages (a multiply in the first two only) and the remainder step.
    always_ff @(posedge aclk) begin
        if (ctl.load_in) begin
            cmd_reg <= cmd_t'(s_tuser);
            key_reg <= s_tdata[31:0];
            val_reg <= s_tdata[32 +: SVW];
        end else if (ctl.swap) begin
            key_reg <= q_key;
            val_reg <= q_val;
        end
        if (ctl.hash1) x_reg <= mix16(key_reg) * MIX_MULT;
        if (ctl.hash2) x_reg <= mix16(x_reg) * MIX_MULT;
        if (ctl.hash3) begin
            hsh_reg <= mix16(x_reg);
            r_reg   <= '0;
            bit_reg <= '0;
        end else if (ctl.mod_step) begin
            // Reciprocal estimate of the quotient, at most one low, then one correction.
            if (bit_reg == 5'd0) begin
                qt_reg <= prod[63:32];
            end else begin
                r_reg <= (rem_est >= NS) ? IW'(rem_est - NS) : rem_est[IW-1:0];
            end
            bit_reg <= bit_reg + 1'b1;
        end
    end

    // Slot pointer; the memory reads at the pointer's next value.
    always_comb begin
        case (ctl.idx_op)
            IDX_HOME: idx_next = home;
            IDX_NEXT: idx_next = idx_inc;
            IDX_ZERO: idx_next = '0;
            default:  idx_next = idx_reg;
        endcase
    end

    // Slot pointer, probe distance, hole and step counters, entry count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            cnt_reg <= '0;
        end else begin
            idx_reg <= idx_next;
            case (ctl.cnt_op)
                CNT_INC:  cnt_reg <= cnt_reg + 1'b1;
                CNT_DEC:  cnt_reg <= cnt_reg - 1'b1;
                CNT_ZERO: cnt_reg <= '0;
                default:  cnt_reg <= cnt_reg;
            endcase
        end
        case (ctl.dist_op)
            DIST_ZERO: dist_reg <= '0;
            DIST_INC:  dist_reg <= dist_reg + 1'b1;
            DIST_QINC: dist_reg <= q_dist + 1'b1;
            default:   dist_reg <= dist_reg;
        endcase
        if (ctl.hole_load) hole_reg <= idx_reg;
        if (ctl.step_clr) step_reg <= '0;
        else if (ctl.step_inc) step_reg <= step_reg + 1'b1;
    end

    // Write port selection.
    always_comb begin
        we = 1'b1;
        wa = idx_reg;
        wd = '0;
        case (ctl.wr_op)
            WR_CLEAR:  wd = '0;
            WR_UPDATE: wd = {1'b1, q_dist, q_key, val_reg};
            WR_TRAVEL: wd = {1'b1, dist_reg, key_reg, val_reg};
            WR_SHIFT: begin
                wa = hole_reg;
                wd = {1'b1, q_dist - 1'b1, q_key, q_val};
            end
            WR_EMPTY: wa = hole_reg;
            default:  we = 1'b0;
        endcase
    end

    // Slot memory: one write, one registered read.
    always_ff @(posedge aclk) begin
        if (we) mem[wa] <= wd;
        q_reg <= mem[idx_next];
    end

    // Result capture and the output register.
    always_ff @(posedge aclk) begin
        if (ctl.set_res) begin
            res_reg  <= ctl.res_code;
            vout_reg <= ctl.res_from_q ? 32'(q_val) : 32'd0;
        end
        if (ctl.load_out) begin
            out_status_reg <= res_reg;
            out_vout_reg   <= vout_reg;
            out_count_reg  <= 7'(cnt_reg);
        end
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctl.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_count_reg, out_vout_reg};
    assign m_tuser  = out_status_reg;

    // Status towards the controller.
    assign lim    = (LW'(max_entries) > LW'(TABLE_SLOTS)) ? LW'(TABLE_SLOTS)
                                                           : LW'(max_entries);
    assign poorer = !q_occ || (q_dist < dist_reg);

    always_comb begin
        st.cmd        = cmd_reg;
        st.pow2       = POW2;
        st.mod_last   = (bit_reg == 5'd1);
        st.hit        = !poorer && (q_key == key_reg);
        st.miss       = poorer || (q_key != key_reg && dist_reg == LAST);
        st.empty      = !q_occ;
        st.richer     = dist_reg > q_dist;
        st.shift_stop = !q_occ || (q_dist == '0) || (step_reg == NS);
        st.sweep_last = (idx_reg == LAST);
        st.room       = LW'(cnt_reg) < lim;
        st.out_busy   = out_valid_reg && !m_tready;
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (CW + 1)'(cnt_reg) <= (CW + 1)'(TABLE_SLOTS))
        else $error("entry count above slot count");

    a_cnt_inc: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.cnt_op == CNT_INC) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("entry count did not advance on insert");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.load_out |=> (m_tvalid && m_tuser == $past(res_reg)))
        else $error("result not presented after load");

endmodule

@@ bench/testbench.sv @@
module testbench;
    import rhh_pkg::*;

    localparam int SLOTS = 64;
    localparam int CYCLE_LIMIT = 2000000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    typedef struct packed {
        res_t        status;
        logic [31:0] value_out;
        logic [6:0]  entry_count;
    } outcome_t;

    int errors;
    int cycles;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_off;

    // Reports one mismatch and counts it.
    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    // Mirror of the table and the scoreboard of expected outcomes.
    class hash_scoreboard;
        logic [31:0] keys [SLOTS];
        logic [31:0] vals [SLOTS];
        bit          used [SLOTS];
        int          probe_dist [SLOTS];
        int          count;
        int          limit;
        outcome_t    pending [$];
        logic [31:0] live_keys [$];

        function new();
            foreach (used[i]) begin
                used[i] = 0;
                probe_dist[i] = 0;
            end
            count = 0;
            limit = 48;
        endfunction

        function int home_of(input logic [31:0] k);
            logic [31:0] h;
            h = (({{16{k[31]}}, k[31:16]}) ^ k) * 32'h045d9f3b;
            h = (({{16{h[31]}}, h[31:16]}) ^ h) * 32'h045d9f3b;
            h = ({{16{h[31]}}, h[31:16]}) ^ h;
            return h % SLOTS;
        endfunction

        function int locate(input logic [31:0] k);
            int idx;
            idx = home_of(k);
            for (int d = 0; d < SLOTS; d++) begin
                if (!used[idx] || probe_dist[idx] < d) return -1;
                if (keys[idx] == k) return idx;
                idx = (idx + 1) % SLOTS;
            end
            return -1;
        endfunction

        function void place(input logic [31:0] k, input logic [31:0] v);
            int idx;
            int d;
            logic [31:0] tk;
            logic [31:0] tv;
            int td;
            idx = home_of(k);
            d = 0;
            for (int s = 0; s < SLOTS; s++) begin
                if (!used[idx]) begin
                    keys[idx] = k;
                    vals[idx] = v;
                    probe_dist[idx] = d;
                    used[idx] = 1;
                    count++;
                    return;
                end
                if (d > probe_dist[idx]) begin
                    tk = keys[idx];
                    tv = vals[idx];
                    td = probe_dist[idx];
                    keys[idx] = k;
                    vals[idx] = v;
                    probe_dist[idx] = d;
                    k = tk;
                    v = tv;
                    d = td;
                end
                idx = (idx + 1) % SLOTS;
                d++;
            end
        endfunction

        function void pull_back(input int idx);
            int nxt;
            nxt = (idx + 1) % SLOTS;
            used[idx] = 0;
            probe_dist[idx] = 0;
            count--;
            for (int s = 0; s < SLOTS; s++) begin
                if (!used[nxt] || probe_dist[nxt] == 0) break;
                keys[idx] = keys[nxt];
                vals[idx] = vals[nxt];
                probe_dist[idx] = probe_dist[nxt] - 1;
                used[idx] = 1;
                used[nxt] = 0;
                probe_dist[nxt] = 0;
                idx = nxt;
                nxt = (nxt + 1) % SLOTS;
            end
        endfunction

        // Notes an accepted item and queues the outcome it must give.
        function void note_item(input cmd_t c, input logic [31:0] k, input logic [31:0] v);
            outcome_t o;
            int idx;
            int lim;
            lim = (limit > SLOTS) ? SLOTS : limit;
            o.value_out = '0;
            case (c)
                CMD_INSERT: begin
                    idx = locate(k);
                    if (idx >= 0) begin
                        o.value_out = vals[idx];
                        vals[idx] = v;
                        o.status = RES_UPDATED;
                    end else if (count >= lim) begin
                        o.status = RES_FULL;
                    end else begin
                        place(k, v);
                        live_keys.push_back(k);
                        o.status = RES_NEW;
                    end
                end
                CMD_LOOKUP, CMD_REMOVE: begin
                    idx = locate(k);
                    if (idx < 0) begin
                        o.status = RES_NOT_FOUND;
                    end else begin
                        o.value_out = vals[idx];
                        if (c == CMD_REMOVE) begin
                            pull_back(idx);
                            o.status = RES_REMOVED;
                        end else begin
                            o.status = RES_FOUND;
                        end
                    end
                end
                default: begin
                    foreach (used[i]) begin
                        used[i] = 0;
                        probe_dist[i] = 0;
                    end
                    count = 0;
                    live_keys.delete();
                    o.status = RES_CLEARED;
                end
            endcase
            o.entry_count = count[6:0];
            pending.push_back(o);
        endfunction

        // Checks one result against the oldest expectation.
        task check_result(input logic [2:0] st, input logic [39:0] d);
            outcome_t o;
            if (pending.size() == 0) begin
                report("unexpected item", {st, d}, 0);
                return;
            end
            o = pending.pop_front();
            if (st !== o.status) report("status", st, o.status);
            if (d[31:0] !== o.value_out) report("value_out", d[31:0], o.value_out);
            if (d[38:32] !== o.entry_count) report("entry_count", d[38:32], o.entry_count);
            if (d[39] !== 1'b0) report("pad bit", d[39], 0);
        endtask
    endclass

    hash_scoreboard board;

    robin_hood_hash_table_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Clock.
    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    // Cycle counter and timeout.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout");
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: sample at the rising edge, decide ready at the falling edge.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tuser, m_tdata);
    end

    always @(negedge aclk) begin
        if (!aresetn || hold_off) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // APB register write: setup then access.
    task automatic write_limit(input int v);
        @(negedge aclk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= 3'd0; pwdata <= v;
        @(negedge aclk);
        penable <= 1;
        @(negedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        board.limit = v & 32'h7f;
    endtask

    // Offers one item, with random gaps before it, until it is accepted.
    task automatic send_item(input cmd_t c, input logic [31:0] k, input logic [31:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= c;
        s_tdata <= {v, k};
        do @(posedge aclk); while (!s_tready);
        board.note_item(c, k, v);
        @(negedge aclk);
    endtask

    task automatic release_valid();
        s_tvalid <= 0;
    endtask

    // Waits until every expected result has come, then lets the block settle.
    task automatic drain();
        release_valid();
        while (board.pending.size() != 0) @(negedge aclk);
        repeat (SLOTS + 20) @(negedge aclk);
    endtask

    function automatic logic [31:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 55 && board.live_keys.size() != 0)
            return board.live_keys[$urandom_range(board.live_keys.size() - 1)];
        if (r < 85) return $urandom_range(40) - 20;
        return $urandom;
    endfunction

    task automatic random_phase(input int n, input int lim);
        int r;
        cmd_t c;
        write_limit(lim);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 50) c = CMD_INSERT;
            else if (r < 72) c = CMD_LOOKUP;
            else if (r < 98) c = CMD_REMOVE;
            else c = CMD_CLEAR;
            send_item(c, pick_key(), $urandom);
        end
        drain();
    endtask

    initial begin
        board = new();
        errors = 0;
        cycles = 0;
        hold_off = 0;
        send_idle_pct = 22;
        recv_idle_pct = 60;
        aresetn = 0;
        s_tvalid = 0; s_tdata = '0; s_tuser = CMD_INSERT;
        m_tready = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        repeat (10) @(negedge aclk);
        aresetn <= 1;

        // Directed: extremes, every command, default limit, then limits 0, 1 and 127.
        send_item(CMD_LOOKUP, 32'h0, 32'h0);
        send_item(CMD_REMOVE, 32'h8000_0000, 32'h0);
        send_item(CMD_INSERT, 32'h8000_0000, 32'hffff_ffff);
        send_item(CMD_INSERT, 32'h7fff_ffff, 32'h0);
        send_item(CMD_INSERT, 32'hffff_ffff, 32'h5555_aaaa);
        send_item(CMD_INSERT, 32'h8000_0000, 32'haaaa_5555);
        send_item(CMD_LOOKUP, 32'h7fff_ffff, 32'h1234);
        send_item(CMD_REMOVE, 32'hffff_ffff, 32'h0);
        send_item(CMD_LOOKUP, 32'hffff_ffff, 32'h0);
        send_item(CMD_CLEAR, 32'hdead_beef, 32'hffff_ffff);
        send_item(CMD_LOOKUP, 32'h8000_0000, 32'h0);
        drain();
        write_limit(0);
        send_item(CMD_INSERT, 32'h1, 32'h1);
        drain();
        write_limit(1);
        send_item(CMD_INSERT, 32'h1, 32'h11);
        send_item(CMD_INSERT, 32'h2, 32'h22);
        send_item(CMD_INSERT, 32'h1, 32'h33);
        drain();
        write_limit(0);
        send_item(CMD_INSERT, 32'h1, 32'h44);
        send_item(CMD_INSERT, 32'h3, 32'h44);
        drain();
        write_limit(127);
        for (int i = 0; i < 8; i++) send_item(CMD_INSERT, i * 64, ~i);
        drain();

        // Long receiver hold-off while items keep being offered.
        hold_off = 1;
        fork
            begin
                repeat (400) @(negedge aclk);
                hold_off = 0;
            end
            for (int i = 0; i < 6; i++) send_item(CMD_LOOKUP, i * 64, 0);
        join
        drain();

        random_phase(250, 64);
        random_phase(200, 127);
        send_idle_pct = 60;
        recv_idle_pct = 22;
        random_phase(250, 5);
        random_phase(250, 48);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(250, 64);
        random_phase(300, 20);

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

@@ robin_hood_hash_table_unit.f @@
sv/rhh_pkg.sv
sv/rhh_ctrl.sv
sv/rhh_datapath.sv
sv/robin_hood_hash_table_unit.sv
bench/testbench.sv
